### rtl/falling_particle_grid_step_core_macros.svh
// Assertion macros shared by the falling particle grid step checker.
`ifndef FALLING_PARTICLE_GRID_STEP_CORE_MACROS_SVH
`define FALLING_PARTICLE_GRID_STEP_CORE_MACROS_SVH

// Same-cycle implication, sampled on the rising clock edge, off during reset.
`define FPG_ASSERT_IMPL(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on the rising clock edge, off during reset.
`define FPG_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### rtl/fpg_pkg.sv
// Types, codes and helpers shared by the falling particle grid step core.
`timescale 1ns / 1ps

package fpg_pkg;

    localparam int OP_W     = 2;
    localparam int COL_W    = 9;
    localparam int ROW_W    = 8;
    localparam int COLOR_W  = 8;
    localparam int STATUS_W = 4;

    localparam logic [OP_W-1:0] OP_LOAD    = 2'd0;
    localparam logic [OP_W-1:0] OP_PLACE   = 2'd1;
    localparam logic [OP_W-1:0] OP_ADVANCE = 2'd2;

    localparam logic [STATUS_W-1:0] ST_DOWN       = 4'd0;
    localparam logic [STATUS_W-1:0] ST_LEFT       = 4'd1;
    localparam logic [STATUS_W-1:0] ST_RIGHT      = 4'd2;
    localparam logic [STATUS_W-1:0] ST_SPAWNED    = 4'd3;
    localparam logic [STATUS_W-1:0] ST_SPAWN_BUSY = 4'd4;
    localparam logic [STATUS_W-1:0] ST_PLACED     = 4'd5;
    localparam logic [STATUS_W-1:0] ST_PLACE_BUSY = 4'd6;
    localparam logic [STATUS_W-1:0] ST_REJECTED   = 4'd7;
    localparam logic [STATUS_W-1:0] ST_LOADED     = 4'd8;

    localparam logic [COLOR_W-1:0] PARTICLE_COLOR_RESET = 8'h0F;

    typedef struct packed {
        logic [OP_W-1:0]    opcode;
        logic [COL_W-1:0]   pixel_x;
        logic [ROW_W-1:0]   pixel_y;
        logic [COLOR_W-1:0] pixel_color;
        logic [COL_W-1:0]   random_column;
    } t_in;

    typedef struct packed {
        logic                write_valid;
        logic [COL_W-1:0]    write_x;
        logic [ROW_W-1:0]    write_y;
        logic [COLOR_W-1:0]  write_color;
        logic [STATUS_W-1:0] status;
        logic                last;
    } t_out;

    typedef struct packed {
        logic [COL_W-1:0] col;
        logic [ROW_W-1:0] row;
    } t_particle;

    typedef enum logic [4:0] {
        S_CLEAR,
        S_IDLE,
        S_DECODE,
        S_LD_WR,
        S_PL_CHK,
        S_AD_LST,
        S_PROBE_D,
        S_PROBE_L,
        S_PROBE_R,
        S_MV_NEW,
        S_MV_OLD,
        S_SH_RD,
        S_SH_WR,
        S_SP_RD,
        S_SP_CHK,
        S_EMIT_A,
        S_EMIT_B
    } t_state;

    function automatic t_out mk_result(logic wv, logic [COL_W-1:0] x, logic [ROW_W-1:0] y,
                                       logic [COLOR_W-1:0] c, logic [STATUS_W-1:0] st,
                                       logic lst);
        t_out r;
        r.write_valid = wv;
        r.write_x     = x;
        r.write_y     = y;
        r.write_color = c;
        r.status      = st;
        r.last        = lst;
        return r;
    endfunction

    // Result with no pixel write, closing the item.
    function automatic t_out mk_status(logic [STATUS_W-1:0] st);
        return mk_result(1'b0, '0, '0, '0, st, 1'b1);
    endfunction

endpackage

### rtl/fpg_cell_unit.sv
// Shared cell unit: tests one bit of an occupancy row and returns the row with it rewritten.
`timescale 1ns / 1ps

module fpg_cell_unit
    import fpg_pkg::*;
#(
    parameter int WIDTH = 320
) (
    input  logic [WIDTH-1:0] i_row,
    input  logic [COL_W-1:0] i_x,
    input  logic             i_val,
    output logic             o_bit,
    output logic [WIDTH-1:0] o_row
);

    localparam int XW = $clog2(WIDTH);

    logic [XW-1:0] ix;
    logic          in_range;

    assign ix       = XW'(i_x);
    assign in_range = (i_x < WIDTH);

    always_comb begin
        o_row = i_row;
        o_bit = 1'b0;
        if (in_range) begin
            o_bit     = i_row[ix];
            o_row[ix] = i_val;
        end
    end

endmodule

### rtl/fpg_occ_mem.sv
// Occupancy memory: one row of the screen per entry, registered read.
`timescale 1ns / 1ps

module fpg_occ_mem #(
    parameter int  DEPTH = 200,
    parameter int  WIDTH = 320,
    localparam int AW    = $clog2(DEPTH)
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // read data holds until the next read
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

### rtl/fpg_list_mem.sv
// Particle list memory: column and row per entry, registered read.
`timescale 1ns / 1ps

module fpg_list_mem
    import fpg_pkg::*;
#(
    parameter int  DEPTH = 200,
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic          i_clk,
    input  logic          i_we,
    input  logic [AW-1:0] i_waddr,
    input  t_particle     i_wdata,
    input  logic          i_re,
    input  logic [AW-1:0] i_raddr,
    output t_particle     o_rdata
);

    t_particle r_mem [DEPTH];
    t_particle r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

### rtl/falling_particle_grid_step_core.sv
// Top level of the falling particle grid step core: sequencer, list and occupancy control.
`timescale 1ns / 1ps
//
//  channel   direction  handshake                  payload
//  in        input      i_in_valid / o_in_ready    i_in_data  (t_in)
//  out       output     o_out_valid / i_out_ready  o_out_data (t_out), 1 or 2 items per input
//  cfg       input      i_cfg_valid / o_cfg_ready  i_cfg_data (particle colour)
//
//  A move probes straight down, then left, then right as needed; probes run one per cycle
//  through the shared cell unit. A halt shifts each list entry behind the cursor, then
//  runs the spawn check.
//  Reset: a clearing pass writes every occupancy row once, during which o_in_ready stays
//  low; configuration writes are taken throughout.
//  Stalls: results sit in an output register, so a new item is taken while the last
//  result still waits; a held second result keeps the sequencer in its emit state.
//
module falling_particle_grid_step_core
    import fpg_pkg::*;
#(
    parameter int SCREEN_WIDTH   = 320,
    parameter int SCREEN_HEIGHT  = 200,
    parameter int PARTICLE_COUNT = 200
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  t_in                i_in_data,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output t_out               o_out_data,
    input  logic               i_cfg_valid,
    output logic               o_cfg_ready,
    input  logic [COLOR_W-1:0] i_cfg_data
);

    localparam int RW = $clog2(SCREEN_HEIGHT);                          // occupancy row index
    localparam int LW = (PARTICLE_COUNT > 1) ? $clog2(PARTICLE_COUNT) : 1; // list index
    localparam int CW = $clog2(PARTICLE_COUNT + 1);                     // placed count

    // ---- state ----
    t_state              r_state, n_state;
    logic [RW-1:0]       r_clr, n_clr;          // clearing pass row
    t_in                 r_item, n_item;
    logic [COL_W-1:0]    r_cx, n_cx;            // particle under the cursor
    logic [ROW_W-1:0]    r_cy, n_cy;
    logic [COL_W-1:0]    r_nx, n_nx;            // chosen destination column
    logic [STATUS_W-1:0] r_st, n_st;            // move direction
    logic [LW-1:0]       r_j, n_j;              // shift index
    logic [LW-1:0]       r_cursor, n_cursor;
    logic [CW-1:0]       r_placed, n_placed;
    logic                r_pending, n_pending;  // spawn retry owed
    t_out                r_res_a, n_res_a;
    t_out                r_res_b, n_res_b;
    logic                r_two, n_two;          // move: two results
    logic                r_out_valid;
    t_out                r_out_data;
    logic [COLOR_W-1:0]  r_color;

    // ---- memory and shared unit strobes ----
    logic                    occ_we, occ_re;
    logic [RW-1:0]           occ_waddr, occ_raddr;
    logic [SCREEN_WIDTH-1:0] occ_wdata, occ_rdata;
    logic                    lst_we, lst_re;
    logic [LW-1:0]           lst_waddr, lst_raddr;
    t_particle               lst_wdata, lst_rdata;
    logic [COL_W-1:0]        unit_x;
    logic                    unit_val;
    logic                    unit_bit;
    logic [SCREEN_WIDTH-1:0] unit_row;
    logic                    out_load, out_sel_b;

    // ---- decode helpers ----
    logic             in_accept, slot_free;
    logic             ld_bad, pl_bad, col_bad, lst_bad, lst_bottom;
    logic [ROW_W-1:0] ny, lst_ny;
    logic [LW-1:0]    cursor_step;

    assign in_accept   = i_in_valid && o_in_ready;
    assign slot_free   = !r_out_valid || i_out_ready;
    assign ld_bad      = (r_item.pixel_x >= SCREEN_WIDTH) || (r_item.pixel_y >= SCREEN_HEIGHT);
    assign col_bad     = (r_item.random_column >= SCREEN_WIDTH);
    assign pl_bad      = (r_placed >= PARTICLE_COUNT) || (r_placed >= SCREEN_HEIGHT) || col_bad;
    assign lst_bad     = (lst_rdata.col >= SCREEN_WIDTH) || (lst_rdata.row >= SCREEN_HEIGHT);
    assign lst_bottom  = (lst_rdata.row == SCREEN_HEIGHT - 1);
    assign ny          = ROW_W'(r_cy + 1'b1);
    assign lst_ny      = ROW_W'(lst_rdata.row + 1'b1);
    assign cursor_step = (r_cursor == LW'(PARTICLE_COUNT - 1)) ? '0 : LW'(r_cursor + 1'b1);

    // ---- submodules ----
    fpg_occ_mem #(
        .DEPTH (SCREEN_HEIGHT),
        .WIDTH (SCREEN_WIDTH)
    ) u_occ (
        .i_clk   (i_clk),
        .i_we    (occ_we),
        .i_waddr (occ_waddr),
        .i_wdata (occ_wdata),
        .i_re    (occ_re),
        .i_raddr (occ_raddr),
        .o_rdata (occ_rdata)
    );

    fpg_list_mem #(
        .DEPTH (PARTICLE_COUNT)
    ) u_list (
        .i_clk   (i_clk),
        .i_we    (lst_we),
        .i_waddr (lst_waddr),
        .i_wdata (lst_wdata),
        .i_re    (lst_re),
        .i_raddr (lst_raddr),
        .o_rdata (lst_rdata)
    );

    // every cell test and cell write goes through this one unit
    fpg_cell_unit #(
        .WIDTH (SCREEN_WIDTH)
    ) u_cell (
        .i_row (occ_rdata),
        .i_x   (unit_x),
        .i_val (unit_val),
        .o_bit (unit_bit),
        .o_row (unit_row)
    );

    // ---- next state ----
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_CLEAR: begin
                if (r_clr == RW'(SCREEN_HEIGHT - 1)) n_state = S_IDLE;
            end
            S_IDLE: begin
                if (in_accept) n_state = S_DECODE;
            end
            S_DECODE: begin
                unique case (r_item.opcode)
                    OP_LOAD:    n_state = ld_bad ? S_EMIT_A : S_LD_WR;
                    OP_PLACE:   n_state = pl_bad ? S_EMIT_A : S_PL_CHK;
                    OP_ADVANCE: begin
                        if (r_placed < PARTICLE_COUNT) n_state = S_EMIT_A;
                        else if (r_pending)            n_state = S_SP_RD;
                        else                           n_state = S_AD_LST;
                    end
                    default:    n_state = S_EMIT_A;
                endcase
            end
            S_LD_WR, S_PL_CHK, S_MV_OLD, S_SP_CHK: n_state = S_EMIT_A;
            S_AD_LST: begin
                priority if (lst_bad)    n_state = S_EMIT_A;
                else if (lst_bottom)     n_state = S_SH_RD;
                else                     n_state = S_PROBE_D;
            end
            S_PROBE_D: n_state = unit_bit ? S_PROBE_L : S_MV_NEW;
            S_PROBE_L: n_state = (r_cx != '0 && !unit_bit) ? S_MV_NEW : S_PROBE_R;
            S_PROBE_R: begin
                n_state = (r_cx != COL_W'(SCREEN_WIDTH - 1) && !unit_bit) ? S_MV_NEW : S_SH_RD;
            end
            S_MV_NEW:  n_state = S_MV_OLD;
            S_SH_RD:   n_state = (r_j == LW'(PARTICLE_COUNT - 1)) ? S_SP_RD : S_SH_WR;
            S_SH_WR:   n_state = S_SH_RD;
            S_SP_RD:   n_state = S_SP_CHK;
            S_EMIT_A: begin
                if (slot_free) n_state = r_two ? S_EMIT_B : S_IDLE;
            end
            S_EMIT_B: begin
                if (slot_free) n_state = S_IDLE;
            end
            default:   n_state = S_IDLE;
        endcase
    end

    // ---- strobes to memories, cell unit and output register ----
    always_comb begin
        o_in_ready = 1'b0;
        occ_we     = 1'b0;
        occ_waddr  = RW'(r_cy);
        occ_wdata  = unit_row;
        occ_re     = 1'b0;
        occ_raddr  = RW'(ny);
        lst_we     = 1'b0;
        lst_waddr  = r_cursor;
        lst_wdata  = '{col: r_nx, row: ny};
        lst_re     = 1'b0;
        lst_raddr  = r_cursor;
        unit_x     = r_cx;
        unit_val   = 1'b0;
        out_load   = 1'b0;
        out_sel_b  = 1'b0;
        unique case (r_state)
            S_CLEAR: begin
                occ_we    = 1'b1;
                occ_waddr = r_clr;
                occ_wdata = '0;
            end
            S_IDLE: o_in_ready = 1'b1;
            S_DECODE: begin
                if (r_item.opcode == OP_LOAD && !ld_bad) begin
                    occ_re    = 1'b1;
                    occ_raddr = RW'(r_item.pixel_y);
                end else if (r_item.opcode == OP_PLACE && !pl_bad) begin
                    occ_re    = 1'b1;
                    occ_raddr = RW'(r_placed);
                end else if (r_item.opcode == OP_ADVANCE) begin
                    lst_re = 1'b1;
                end
            end
            S_LD_WR: begin
                unit_x    = r_item.pixel_x;
                unit_val  = (r_item.pixel_color != '0);
                occ_we    = 1'b1;
                occ_waddr = RW'(r_item.pixel_y);
            end
            S_PL_CHK: begin
                unit_x    = r_item.random_column;
                unit_val  = 1'b1;
                occ_we    = !unit_bit;
                occ_waddr = RW'(r_placed);
                lst_we    = !unit_bit;
                lst_waddr = LW'(r_placed);
                lst_wdata = '{col: r_item.random_column, row: ROW_W'(r_placed)};
            end
            S_AD_LST: begin
                occ_re    = !lst_bad && !lst_bottom;
                occ_raddr = RW'(lst_ny);
            end
            S_PROBE_D: unit_x = r_cx;
            S_PROBE_L: unit_x = COL_W'(r_cx - 1'b1);
            S_PROBE_R: unit_x = COL_W'(r_cx + 1'b1);
            S_MV_NEW: begin
                // set the destination, fetch the source row behind it
                unit_x    = r_nx;
                unit_val  = 1'b1;
                occ_we    = 1'b1;
                occ_waddr = RW'(ny);
                occ_re    = 1'b1;
                occ_raddr = RW'(r_cy);
            end
            S_MV_OLD: begin
                unit_x    = r_cx;
                occ_we    = 1'b1;
                occ_waddr = RW'(r_cy);
                lst_we    = 1'b1;
            end
            S_SH_RD: begin
                lst_re    = (r_j != LW'(PARTICLE_COUNT - 1));
                lst_raddr = LW'(r_j + 1'b1);
            end
            S_SH_WR: begin
                lst_we    = 1'b1;
                lst_waddr = r_j;
                lst_wdata = lst_rdata;
            end
            S_SP_RD: begin
                occ_re    = 1'b1;
                occ_raddr = '0;
            end
            S_SP_CHK: begin
                unit_x    = r_item.random_column;
                unit_val  = 1'b1;
                occ_we    = !col_bad && !unit_bit;
                occ_waddr = '0;
                lst_we    = !col_bad && !unit_bit;
                lst_waddr = LW'(PARTICLE_COUNT - 1);
                lst_wdata = '{col: r_item.random_column, row: '0};
            end
            S_EMIT_A: out_load = slot_free;
            S_EMIT_B: begin
                out_load  = slot_free;
                out_sel_b = 1'b1;
            end
            default: ;
        endcase
    end

    // ---- datapath next values ----
    always_comb begin
        n_clr     = r_clr;
        n_item    = r_item;
        n_cx      = r_cx;
        n_cy      = r_cy;
        n_nx      = r_nx;
        n_st      = r_st;
        n_j       = r_j;
        n_cursor  = r_cursor;
        n_placed  = r_placed;
        n_pending = r_pending;
        n_res_a   = r_res_a;
        n_res_b   = r_res_b;
        n_two     = r_two;
        unique case (r_state)
            S_CLEAR: n_clr = RW'(r_clr + 1'b1);
            S_IDLE: begin
                if (in_accept) n_item = i_in_data;
            end
            S_DECODE: begin
                n_two   = 1'b0;
                n_res_a = mk_status(ST_REJECTED);
            end
            S_LD_WR: begin
                n_res_a = mk_result(1'b1, r_item.pixel_x, r_item.pixel_y, r_item.pixel_color,
                                    ST_LOADED, 1'b1);
            end
            S_PL_CHK: begin
                if (unit_bit) begin
                    n_res_a = mk_status(ST_PLACE_BUSY);
                end else begin
                    n_placed = CW'(r_placed + 1'b1);
                    n_res_a  = mk_result(1'b1, r_item.random_column, ROW_W'(r_placed),
                                         r_color, ST_PLACED, 1'b1);
                end
            end
            S_AD_LST: begin
                n_cx = lst_rdata.col;
                n_cy = lst_rdata.row;
                n_j  = r_cursor;
            end
            S_PROBE_D: begin
                n_nx = r_cx;
                n_st = ST_DOWN;
            end
            S_PROBE_L: begin
                if (!unit_bit) begin
                    n_nx = COL_W'(r_cx - 1'b1);
                    n_st = ST_LEFT;
                end
            end
            S_PROBE_R: begin
                if (!unit_bit) begin
                    n_nx = COL_W'(r_cx + 1'b1);
                    n_st = ST_RIGHT;
                end
            end
            S_MV_OLD: begin
                n_two    = 1'b1;
                n_res_a  = mk_result(1'b1, r_cx, r_cy, '0, r_st, 1'b0);
                n_res_b  = mk_result(1'b1, r_nx, ny, r_color, r_st, 1'b1);
                n_cursor = cursor_step;
            end
            S_SH_WR: n_j = LW'(r_j + 1'b1);
            S_SP_CHK: begin
                if (col_bad || unit_bit) begin
                    n_pending = 1'b1;
                    n_res_a   = mk_status(ST_SPAWN_BUSY);
                end else begin
                    n_pending = 1'b0;
                    n_cursor  = cursor_step;
                    n_res_a   = mk_result(1'b1, r_item.random_column, '0, r_color,
                                          ST_SPAWNED, 1'b1);
                end
            end
            default: ;
        endcase
    end

    // ---- registers ----
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_CLEAR;
            r_clr     <= '0;
            r_cursor  <= '0;
            r_placed  <= '0;
            r_pending <= 1'b0;
            r_two     <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_clr     <= n_clr;
            r_cursor  <= n_cursor;
            r_placed  <= n_placed;
            r_pending <= n_pending;
            r_two     <= n_two;
        end
    end

    always_ff @(posedge i_clk) begin
        r_item  <= n_item;
        r_cx    <= n_cx;
        r_cy    <= n_cy;
        r_nx    <= n_nx;
        r_st    <= n_st;
        r_j     <= n_j;
        r_res_a <= n_res_a;
        r_res_b <= n_res_b;
    end

    // output register: holds each result until the consumer takes it
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_load) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_out_data <= out_sel_b ? r_res_b : r_res_a;
        end
    end

    // particle colour register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_color <= PARTICLE_COLOR_RESET;
        end else if (i_cfg_valid) begin
            r_color <= i_cfg_data;
        end
    end

    assign o_cfg_ready = 1'b1;
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

endmodule

### rtl/fpg_checker.sv
// Port checker for the falling particle grid step core, bound to the top level.
`timescale 1ns / 1ps
`include "falling_particle_grid_step_core_macros.svh"

module fpg_checker
    import fpg_pkg::*;
(
    input logic i_clk,
    input logic i_rst_n,
    input logic o_in_ready,
    input logic o_out_valid,
    input logic i_out_ready,
    input t_out o_out_data
);

    `FPG_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, o_out_valid && !i_out_ready, o_out_valid && $stable(o_out_data), "result dropped or changed while stalled")

    `FPG_ASSERT_IMPL(a_nowrite_zero, i_clk, i_rst_n, o_out_valid && !o_out_data.write_valid, o_out_data.write_x == '0 && o_out_data.write_y == '0 && o_out_data.write_color == '0, "result without a write carries pixel data")

    `FPG_ASSERT_IMPL(a_first_is_clear, i_clk, i_rst_n, o_out_valid && !o_out_data.last, o_out_data.write_valid && o_out_data.write_color == '0 && (o_out_data.status == ST_DOWN || o_out_data.status == ST_LEFT || o_out_data.status == ST_RIGHT), "non-final result is not a move clear")

    `FPG_ASSERT_IMPL(a_busy_mid_move, i_clk, i_rst_n, o_out_valid && !o_out_data.last, !o_in_ready, "input taken before a move finished")

endmodule

bind falling_particle_grid_step_core fpg_checker u_fpg_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .o_in_ready  (o_in_ready),
    .o_out_valid (o_out_valid),
    .i_out_ready (i_out_ready),
    .o_out_data  (o_out_data)
);

### tb/falling_particle_grid_step_core_test.sv
// Self-checking testbench for the falling particle grid step core.
`timescale 1ns / 1ps

module falling_particle_grid_step_core_test;
    import fpg_pkg::*;

    localparam int SCR_W  = 320;
    localparam int SCR_H  = 200;
    localparam int N_PART = 200;

    // opcode left unused by the block; must be rejected
    localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;

    // a halt may shift the whole list and then run the spawn check
    localparam int HALT_CYCLES = 2 * (N_PART - 1) + 16;

    logic               i_clk;
    logic               i_rst_n     = 1'b0;
    logic               i_in_valid  = 1'b0;
    logic               o_in_ready;
    t_in                i_in_data   = '0;
    logic               o_out_valid;
    logic               i_out_ready = 1'b0;
    t_out               o_out_data;
    logic               i_cfg_valid = 1'b0;
    logic               o_cfg_ready;
    logic [COLOR_W-1:0] i_cfg_data  = '0;

    // predicted block state
    bit                 occupied [SCR_H][SCR_W];
    logic [COL_W-1:0]   track_col [N_PART];
    logic [ROW_W-1:0]   track_row [N_PART];
    int                 cursor      = 0;
    int                 placed      = 0;
    bit                 spawn_wait  = 1'b0;
    logic [COLOR_W-1:0] colour_reg  = PARTICLE_COLOR_RESET;

    t_out due_results [$];
    int   fail_count     = 0;
    int   send_idle_pct  = 0;
    int   recv_idle_pct  = 0;
    bit   hold_output    = 1'b0;

    falling_particle_grid_step_core #(
        .SCREEN_WIDTH  (SCR_W),
        .SCREEN_HEIGHT (SCR_H),
        .PARTICLE_COUNT(N_PART)
    ) uut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_in_data  (i_in_data),
        .o_out_valid(o_out_valid),
        .i_out_ready(i_out_ready),
        .o_out_data (o_out_data),
        .i_cfg_valid(i_cfg_valid),
        .o_cfg_ready(o_cfg_ready),
        .i_cfg_data (i_cfg_data)
    );

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    // ---------------------------------------------------------------- predictor

    function automatic void add_result(bit wv, int x, int y, int c,
                                       logic [STATUS_W-1:0] st, bit lst);
        t_out r;
        r.write_valid = wv;
        r.write_x     = COL_W'(x);
        r.write_y     = ROW_W'(y);
        r.write_color = COLOR_W'(c);
        r.status      = st;
        r.last        = lst;
        due_results.push_back(r);
    endfunction

    // new particle at the top of a column, into the tail slot of the list
    function automatic void spawn_particle(int col);
        if (col >= SCR_W || occupied[0][col]) begin
            spawn_wait = 1'b1;
            add_result(1'b0, 0, 0, 0, ST_SPAWN_BUSY, 1'b1);
        end else begin
            spawn_wait             = 1'b0;
            track_col[N_PART - 1]  = COL_W'(col);
            track_row[N_PART - 1]  = '0;
            occupied[0][col]       = 1'b1;
            add_result(1'b1, col, 0, colour_reg, ST_SPAWNED, 1'b1);
            cursor = (cursor + 1) % N_PART;
        end
    endfunction

    function automatic void advance_particle(int col);
        int cx, cy, nx, ny, k;
        logic [STATUS_W-1:0] st;
        cx = track_col[cursor];
        cy = track_row[cursor];
        nx = cx;
        ny = cy + 1;
        if (cx >= SCR_W || cy >= SCR_H) begin
            add_result(1'b0, 0, 0, 0, ST_REJECTED, 1'b1);
            return;
        end
        if (cy == SCR_H - 1) begin
            st = ST_SPAWNED;
        end else if (!occupied[ny][cx]) begin
            st = ST_DOWN;
        end else if (cx != 0 && !occupied[ny][cx - 1]) begin
            st = ST_LEFT;
            nx = cx - 1;
        end else if (cx != SCR_W - 1 && !occupied[ny][cx + 1]) begin
            st = ST_RIGHT;
            nx = cx + 1;
        end else begin
            st = ST_SPAWNED;
        end
        if (st == ST_SPAWNED) begin
            // halted particle stays on screen; later entries close the gap
            for (k = cursor; k < N_PART - 1; k++) begin
                track_col[k] = track_col[k + 1];
                track_row[k] = track_row[k + 1];
            end
            spawn_particle(col);
            return;
        end
        occupied[cy][cx] = 1'b0;
        occupied[ny][nx] = 1'b1;
        track_col[cursor] = COL_W'(nx);
        track_row[cursor] = ROW_W'(ny);
        add_result(1'b1, cx, cy, 0, st, 1'b0);
        add_result(1'b1, nx, ny, colour_reg, st, 1'b1);
        cursor = (cursor + 1) % N_PART;
    endfunction

    function automatic void apply_grid_item(t_in it);
        int px, py, pc, col;
        px  = it.pixel_x;
        py  = it.pixel_y;
        pc  = it.pixel_color;
        col = it.random_column;
        case (it.opcode)
            OP_LOAD: begin
                if (px >= SCR_W || py >= SCR_H) begin
                    add_result(1'b0, 0, 0, 0, ST_REJECTED, 1'b1);
                end else begin
                    occupied[py][px] = (pc != 0);
                    add_result(1'b1, px, py, pc, ST_LOADED, 1'b1);
                end
            end
            OP_PLACE: begin
                if (placed >= N_PART || placed >= SCR_H || col >= SCR_W) begin
                    add_result(1'b0, 0, 0, 0, ST_REJECTED, 1'b1);
                end else if (occupied[placed][col]) begin
                    add_result(1'b0, 0, 0, 0, ST_PLACE_BUSY, 1'b1);
                end else begin
                    track_col[placed]     = COL_W'(col);
                    track_row[placed]     = ROW_W'(placed);
                    occupied[placed][col] = 1'b1;
                    add_result(1'b1, col, placed, colour_reg, ST_PLACED, 1'b1);
                    placed++;
                end
            end
            OP_ADVANCE: begin
                if (placed < N_PART)
                    add_result(1'b0, 0, 0, 0, ST_REJECTED, 1'b1);
                else if (spawn_wait)
                    spawn_particle(col);
                else
                    advance_particle(col);
            end
            default: begin
                add_result(1'b0, 0, 0, 0, ST_REJECTED, 1'b1);
            end
        endcase
    endfunction

    // ---------------------------------------------------------------- checking

    function automatic void check_field(string field, logic [15:0] want, logic [15:0] got);
        if (got !== want) begin
            fail_count++;
            $display("%0t ns: %s mismatch, expected %0d, actual %0d",
                     $time, field, want, got);
        end
    endfunction

    always @(posedge i_clk) begin : check_results
        t_out want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (due_results.size() == 0) begin
                fail_count++;
                $display("%0t ns: unexpected result, expected none, actual %h",
                         $time, o_out_data);
            end else begin
                want = due_results.pop_front();
                check_field("write_valid", want.write_valid, o_out_data.write_valid);
                check_field("write_x",     want.write_x,     o_out_data.write_x);
                check_field("write_y",     want.write_y,     o_out_data.write_y);
                check_field("write_color", want.write_color, o_out_data.write_color);
                check_field("status",      want.status,      o_out_data.status);
                check_field("last",        want.last,        o_out_data.last);
            end
        end
    end

    // receiver: random stalls, or a forced hold-off during the pressure test
    always @(negedge i_clk) begin
        if (hold_output)
            i_out_ready <= 1'b0;
        else
            i_out_ready <= ($urandom_range(99) >= recv_idle_pct);
    end

    // ---------------------------------------------------------------- drivers

    function automatic t_in make_item(logic [OP_W-1:0] op, int x, int y, int c, int col);
        t_in it;
        it.opcode        = op;
        it.pixel_x       = COL_W'(x);
        it.pixel_y       = ROW_W'(y);
        it.pixel_color   = COLOR_W'(c);
        it.random_column = COL_W'(col);
        return it;
    endfunction

    function automatic t_in noise_item(logic [OP_W-1:0] op);
        return make_item(op, $urandom_range(511), $urandom_range(255),
                         $urandom_range(255), $urandom_range(511));
    endfunction

    task automatic send_item(t_in it);
        @(negedge i_clk);
        if ($urandom_range(99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 3)) @(negedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_data  <= it;
        do @(posedge i_clk); while (!o_in_ready);
        apply_grid_item(it);
    endtask

    task automatic finish_phase(int settle);
        @(negedge i_clk);
        i_in_valid <= 1'b0;
        while (due_results.size() != 0) @(posedge i_clk);
        repeat (settle) @(posedge i_clk);
    endtask

    task automatic write_colour(logic [COLOR_W-1:0] value);
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= value;
        do @(posedge i_clk); while (!o_cfg_ready);
        colour_reg = value;
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    // mostly advances, with obstacle bursts under the particle at the cursor
    task automatic send_sweep_items(int count);
        int r, n;
        repeat (count) begin
            r = $urandom_range(99);
            if (r < 70) begin
                send_item(make_item(OP_ADVANCE, $urandom_range(511), $urandom_range(255),
                                    $urandom_range(255),
                                    ($urandom_range(9) < 7) ? $urandom_range(SCR_W - 1)
                                                            : $urandom_range(511)));
            end else if (r < 85) begin
                n = $urandom_range(1, 3);
                repeat (n)
                    send_item(make_item(OP_LOAD,
                                        int'(track_col[cursor]) + int'($urandom_range(2)) - 1,
                                        int'(track_row[cursor]) + 1,
                                        $urandom_range(1, 255), $urandom_range(511)));
            end else if (r < 92) begin
                send_item(noise_item(OP_LOAD));
            end else if (r < 96) begin
                send_item(noise_item(OP_PLACE));
            end else begin
                send_item(noise_item(OP_UNUSED));
            end
        end
    endtask

    // ---------------------------------------------------------------- tests

    task automatic test_edge_cases();
        send_item(noise_item(OP_ADVANCE));                      // list not yet full
        send_item(make_item(OP_UNUSED, 511, 255, 255, 511));
        send_item(make_item(OP_LOAD, 0, 0, 255, 0));
        send_item(make_item(OP_LOAD, SCR_W - 1, SCR_H - 1, 1, 511));
        send_item(make_item(OP_LOAD, SCR_W, 0, 9, 0));          // just off the right edge
        send_item(make_item(OP_LOAD, 0, SCR_H, 9, 0));          // just off the bottom
        send_item(make_item(OP_LOAD, 511, 255, 255, 511));
        send_item(make_item(OP_LOAD, 0, 0, 0, 0));              // zero colour frees the cell
        send_item(make_item(OP_PLACE, 0, 0, 0, SCR_W));         // column off screen
        send_item(make_item(OP_PLACE, 511, 255, 255, 511));
        send_item(make_item(OP_LOAD, 5, 0, 7, 0));
        send_item(make_item(OP_PLACE, 0, 0, 0, 5));             // busy cell
        send_item(make_item(OP_PLACE, 0, 0, 0, 5));
        send_item(make_item(OP_PLACE, 511, 255, 255, 0));
        send_item(make_item(OP_PLACE, 0, 0, 0, SCR_W - 1));
        send_item(noise_item(OP_ADVANCE));
        finish_phase(16);
    endtask

    task automatic test_fill_list();
        int r;
        while (placed < N_PART) begin
            r = $urandom_range(99);
            if (r < 75)
                send_item(make_item(OP_PLACE, $urandom_range(511), $urandom_range(255),
                                    $urandom_range(255), $urandom_range(SCR_W - 1)));
            else if (r < 80)
                send_item(make_item(OP_PLACE, $urandom_range(511), $urandom_range(255),
                                    $urandom_range(255), $urandom_range(SCR_W, 511)));
            else if (r < 92)
                // obstacles on the rows about to be filled: busy places and early blocks
                send_item(make_item(OP_LOAD, $urandom_range(SCR_W - 1),
                                    placed + int'($urandom_range(3)),
                                    $urandom_range(255), $urandom_range(511)));
            else if (r < 96)
                send_item(noise_item(OP_ADVANCE));
            else
                send_item(noise_item(OP_UNUSED));
        end
        // list full: further places are refused
        send_item(make_item(OP_PLACE, 0, 0, 0, 0));
        send_item(make_item(OP_PLACE, 0, 0, 0, SCR_W - 1));
        finish_phase(16);
    endtask

    task automatic test_sweep(int count);
        send_sweep_items(count);
        finish_phase(16);
    endtask

    // output held off for a long stretch while items keep coming
    task automatic test_output_backpressure();
        fork
            begin
                @(posedge i_clk);
                hold_output = 1'b1;
                repeat (400) @(posedge i_clk);
                hold_output = 1'b0;
            end
        join_none
        send_sweep_items(40);
        finish_phase(16);
    endtask

    // ---------------------------------------------------------------- sequence

    initial begin
        repeat (6) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        send_idle_pct = 23;
        recv_idle_pct = 76;
        test_edge_cases();                  // particle colour still at its reset value

        write_colour(8'h00);
        test_fill_list();

        write_colour(8'hFF);
        test_sweep(520);

        write_colour(COLOR_W'($urandom_range(255)));
        send_idle_pct = 76;
        recv_idle_pct = 23;
        test_sweep(520);

        write_colour(COLOR_W'($urandom_range(255)));
        send_idle_pct = 0;
        recv_idle_pct = 0;
        test_sweep(520);
        test_output_backpressure();

        finish_phase(HALT_CYCLES);
        if (fail_count == 0 && due_results.size() == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

    initial begin
        #10_000_000;
        $display("FAILURE");
        $finish;
    end

endmodule
